>>> hw/rtl/label_map_compaction_assert.svh
// Assertion macros shared by the label map compaction modules
`ifndef LABEL_MAP_COMPACTION_ASSERT_SVH
`define LABEL_MAP_COMPACTION_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define LMC_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define LMC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/lmc_pkg.sv
// Types, constants and helpers for the label map compaction block
package lmc_pkg;

    // Largest label that can be surveyed
    localparam int MAX_LABEL = 255;
    // Bits to index a presence bit (labels 1..MAX_LABEL -> 0..MAX_LABEL-1)
    localparam int LAB_W     = $clog2(MAX_LABEL);
    // Bits for a count 0..MAX_LABEL
    localparam int CNT_W     = $clog2(MAX_LABEL + 1);
    // Presence bits are scanned eight at a time
    localparam int GRP_SIZE  = 8;
    localparam int NGRP      = (MAX_LABEL + GRP_SIZE - 1) / GRP_SIZE;
    localparam int GRP_W     = LAB_W - 3;
    localparam int SAT8      = 255;

    // Action codes
    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_SURVEY = 2'd1;
    localparam logic [1:0] ACT_MAP    = 2'd2;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] label;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] new_label;
        logic [7:0] class_count;
        logic       range_error;
    } t_out_beat;

    // Controller to datapath
    typedef struct packed {
        logic load;       // take the input beat
        logic scan_step;  // add one group of presence bits
        logic out_load;   // write the result into the output register
    } t_lmc_cmd;

    // Datapath to controller
    typedef struct packed {
        logic scan_req;   // incoming beat is a map of a valid label
        logic scan_last;  // current group is the label's group
        logic out_free;   // output register can take a result
    } t_lmc_sts;

    // Clamp a count to eight bits
    function automatic logic [7:0] sat8(input logic [CNT_W-1:0] v);
        if ({1'b0, v} > (CNT_W + 1)'(SAT8)) begin
            return 8'hFF;
        end
        return 8'(v);
    endfunction

    // Ones in one group of presence bits
    function automatic logic [3:0] popcnt8(input logic [GRP_SIZE-1:0] v);
        logic [3:0] n;
        n = '0;
        for (int b = 0; b < GRP_SIZE; b++) begin
            n = n + 4'(v[b]);
        end
        return n;
    endfunction

endpackage

>>> hw/rtl/lmc_ctrl.sv
// Controller state machine: accept, rank scan, result hand-off
`include "label_map_compaction_assert.svh"

module lmc_ctrl
    import lmc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_lmc_sts i_sts,
    output t_lmc_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    // Input is taken only between items
    assign o_in_stall = (r_state != S_IDLE);

    // Commands and next state
    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_sts.scan_req ? S_SCAN : S_DONE;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `LMC_ASSERT_NOW(a_cmd_onehot, 1'b1, $onehot0(o_cmd), "controller issued two commands at once")
    `LMC_ASSERT_NEXT(a_out_to_idle, o_cmd.out_load, r_state == S_IDLE, "no return to idle")
    `LMC_ASSERT_NEXT(a_load_stalls, o_cmd.load, o_in_stall, "input open during an item")

endmodule

>>> hw/rtl/lmc_dp.sv
// Datapath: presence bits, class count, rank accumulator, output register
`include "label_map_compaction_assert.svh"

module lmc_dp
    import lmc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_beat  i_in,
    input  t_lmc_cmd  i_cmd,
    output t_lmc_sts  o_sts,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out
);

    localparam int PAD_W = NGRP * GRP_SIZE;

    logic [MAX_LABEL-1:0] r_seen;
    logic [CNT_W-1:0]     r_count;
    logic [1:0]           r_act;
    logic                 r_err;
    logic                 r_lab_ok;
    logic [LAB_W-1:0]     r_idx;
    logic [GRP_W-1:0]     r_grp;
    logic [CNT_W-1:0]     r_acc;
    logic                 r_out_valid;
    t_out_beat            r_out;

    logic                 w_act_lab;
    logic                 w_over;
    logic                 w_lab_ok;
    logic [LAB_W-1:0]     w_idx;
    logic [PAD_W-1:0]     w_seen_pad;
    logic [GRP_W-1:0]     w_last_grp;
    logic [GRP_SIZE-1:0]  w_mask;
    logic [GRP_SIZE-1:0]  w_grp_bits;
    logic [3:0]           w_grp_cnt;

    // Decode the incoming beat
    assign w_act_lab = (i_in.action == ACT_SURVEY) || (i_in.action == ACT_MAP);
    assign w_over    = i_in.label > 16'(MAX_LABEL);
    assign w_lab_ok  = !w_over && (i_in.label != 16'd0);
    assign w_idx     = LAB_W'(i_in.label - 16'd1);

    // Group select for the rank scan
    assign w_seen_pad = PAD_W'(r_seen);
    assign w_last_grp = r_idx[LAB_W-1:3];
    assign w_grp_bits = w_seen_pad[r_grp*GRP_SIZE +: GRP_SIZE];

    always_comb begin
        for (int b = 0; b < GRP_SIZE; b++) begin
            w_mask[b] = (r_grp != w_last_grp) || (3'(b) <= r_idx[2:0]);
        end
    end

    assign w_grp_cnt = popcnt8(w_grp_bits & w_mask);

    // Status to the controller
    assign o_sts.scan_req  = (i_in.action == ACT_MAP) && w_lab_ok;
    assign o_sts.scan_last = (r_grp == w_last_grp);
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;

    // Presence bits and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen  <= '0;
            r_count <= '0;
        end else if (i_cmd.load) begin
            if (i_in.action == ACT_CLEAR) begin
                r_seen  <= '0;
                r_count <= '0;
            end else if (i_in.action == ACT_SURVEY && w_lab_ok && !r_seen[w_idx]) begin
                r_seen[w_idx] <= 1'b1;
                if (r_count < CNT_W'(MAX_LABEL)) begin
                    r_count <= r_count + CNT_W'(1);
                end
            end
        end
    end

    // Held item and rank accumulator
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act    <= i_in.action;
            r_err    <= w_act_lab && w_over;
            r_lab_ok <= w_lab_ok;
            r_idx    <= w_idx;
            r_grp    <= '0;
            r_acc    <= '0;
        end else if (i_cmd.scan_step) begin
            r_grp <= r_grp + GRP_W'(1);
            r_acc <= r_acc + CNT_W'(w_grp_cnt);
        end
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output beat payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.new_label   <= (r_act == ACT_MAP && r_lab_ok && r_seen[r_idx]) ?
                                 sat8(r_acc) : 8'd0;
            r_out.class_count <= sat8(r_count);
            r_out.range_error <= r_err;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `LMC_ASSERT_NOW(a_count_match, 1'b1, r_count == CNT_W'($countones(r_seen)),
        "class count disagrees with presence bits")
    `LMC_ASSERT_NOW(a_scan_bound, i_cmd.scan_step, r_grp <= w_last_grp,
        "rank scan ran past the label's group")
    `LMC_ASSERT_NOW(a_out_slot, i_cmd.out_load, !r_out_valid || !i_out_stall,
        "result written over an untaken beat")

endmodule

>>> hw/rtl/label_map_compaction.sv
// Flow: clear, survey and unused items go from accept straight to the result state; a map
//   item of a valid label first scans G = ((label - 1) >> 3) + 1 groups of eight presence
//   bits, one group a cycle, summing the ones up to the label's own bit. A new item is
//   accepted only once the last one's result has been written into the output register.
// A finished beat may wait in the output register while the next item is accepted.
// Reset (synchronous, active low) clears all presence bits, the count and all valids.
module label_map_compaction
    import lmc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out
);

    t_lmc_cmd w_cmd;
    t_lmc_sts w_sts;

    // Sequencing
    lmc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Storage and arithmetic
    lmc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule
